// File: src/cnv_pkg.sv
// Shared types and constants for the multi-channel 2D convolution core.
// Used by cnv_cell and the top level; depends on nothing.
package cnv_pkg;

   localparam logic [1:0] REQ_PIXEL  = 2'd0;
   localparam logic [1:0] REQ_WEIGHT = 2'd1;
   localparam logic [1:0] REQ_BIAS   = 2'd2;

   localparam logic [2:0] CSR_CHANNELS = 3'd0;
   localparam logic [2:0] CSR_FILTERS  = 3'd1;
   localparam logic [2:0] CSR_KERNEL   = 3'd2;
   localparam logic [2:0] CSR_WIDTH    = 3'd3;
   localparam logic [2:0] CSR_HEIGHT   = 3'd4;

   localparam int FILT_W  = 6;
   localparam int CELL_W  = 9;
   localparam int VALUE_W = 40;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [15:0] pix_c0;
      logic signed [15:0] pix_c1;
      logic signed [15:0] pix_c2;
      logic signed [15:0] pix_c3;
      logic [9:0]         load_addr;
      logic signed [31:0] load_value;
   } req_data_type;

   typedef struct packed {
      logic [2:0]                 out_filter;
      logic [7:0]                 out_row;
      logic [7:0]                 out_col;
      logic signed [VALUE_W-1:0]  out_value;
      logic                       last_of_pixel;
      logic                       last_of_frame;
   } rsp_data_type;

   typedef struct packed {
      logic               en;
      logic [CELL_W-1:0]  idx;
      logic [FILT_W-1:0]  filt;
      logic signed [15:0] value;
   } weight_wr_type;

   typedef struct packed {
      logic [2:0]         filt;
      logic [7:0]         row;
      logic [7:0]         col;
      logic signed [31:0] bias;
      logic               last_pixel;
      logic               last_frame;
   } job_meta_type;

endpackage

// File: src/cnv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module cnv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
endmodule

// File: src/cnv_cell.sv
// One multiply cell: holds the weights of one channel and window position for all filters.
// Depends on cnv_pkg.
module cnv_cell #(
   parameter int MAX_FILTERS = 8,
   parameter int CELL_ID     = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cnv_pkg::weight_wr_type        weight_wr,
   input  logic                          adv,
   input  logic                          use_tap,
   input  logic [cnv_pkg::FILT_W-1:0]    filt,
   input  logic signed [15:0]            tap,
   output logic signed [31:0]            prod_ff
);
   localparam int FW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

   logic signed [15:0] weight_ff [MAX_FILTERS];
   logic signed [31:0] prod_in;

   always_comb begin
      prod_in = use_tap ? (tap * weight_ff[filt[FW-1:0]]) : 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < MAX_FILTERS; f++) begin
            weight_ff[f] <= 16'sd0;
         end
      end else if (weight_wr.en && weight_wr.idx == CELL_ID[cnv_pkg::CELL_W-1:0]) begin
         weight_ff[weight_wr.filt[FW-1:0]] <= weight_wr.value;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
   end
endmodule

// File: src/conv2d_multichannel_forward_core.sv
// Top level of the valid, stride-1, multi-channel 2D convolution core.
// Depends on cnv_pkg, cnv_ram and cnv_cell.
//
//  channel | ports                        | carries
//  req     | req_valid/req_ready/req_data | pixels, weight and bias writes
//  rsp     | rsp_valid/rsp_ready/rsp_data | one result per filter per window
//  csr     | csr_wen/csr_index/csr_wdata  | configuration writes
//
// A pixel that completes a window first shifts the window column in from the line store
// RAMs, then issues one filter per cycle through the row of multiply cells while the rsp
// channel does not stall. A pixel that completes no window holds off requests only while
// its column shifts in; weight, bias and reserved transactions cause no hold-off. Results
// pass the product, row sum, channel sum and output registers. Reset is synchronous; the
// line store needs no clearing. A stalled rsp channel freezes the whole result pipeline.
module conv2d_multichannel_forward_core #(
   parameter int MAX_CHANNELS = 4,
   parameter int MAX_FILTERS  = 8,
   parameter int MAX_KERNEL   = 5,
   parameter int MAX_WIDTH    = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cnv_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cnv_pkg::rsp_data_type rsp_data,
   input  logic                  csr_wen,
   input  logic [2:0]            csr_index,
   input  logic [8:0]            csr_wdata
);
   localparam int C     = MAX_CHANNELS;
   localparam int K     = MAX_KERNEL;
   localparam int CELLS = C * K * K;
   localparam int KIW   = (K > 1) ? $clog2(K) : 1;
   localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int FW    = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
   localparam int VW    = cnv_pkg::VALUE_W;

   logic [2:0] chan_cfg_ff, kern_cfg_ff;
   logic [3:0] filt_cfg_ff;
   logic [8:0] width_cfg_ff, height_cfg_ff;
   int nc, nf, k, w, h;

   logic [CW-1:0]  col_ff;
   logic [7:0]     row_ff;
   logic [KIW-1:0] slot_ff;

   logic           b_valid_ff, b_emit_ff, b_fend_ff;
   logic [KIW-1:0] b_slot_ff;
   logic [63:0]    b_pix_ff;
   logic [7:0]     b_r0_ff, b_c0_ff;

   logic           busy_ff;
   logic [FW-1:0]  fcnt_ff;
   logic           last_issue, adv, accept, pix_accept;

   logic [63:0] win_ff [K][K];
   logic [63:0] col_new [K];
   logic [63:0] rd_data [K];

   logic signed [31:0] bias_ff [MAX_FILTERS];
   logic signed [15:0] tap [CELLS];
   logic               use_tap [CELLS];
   logic signed [31:0] prod [CELLS];
   cnv_pkg::weight_wr_type weight_wr;

   logic                 p_valid_ff, s1_valid_ff, s2_valid_ff, out_valid_ff;
   cnv_pkg::job_meta_type issue_meta, p_meta_ff, s1_meta_ff, s2_meta_ff;
   logic signed [VW-1:0] rsum_ff [C*K];
   logic signed [VW-1:0] csum_ff [C];
   cnv_pkg::rsp_data_type rsp_data_ff;

   int row_i, col_i, r0_i, c0_i, wf, widx;
   logic [63:0] packed_pix;
   logic emit, frame_end;
   logic signed [31:0] wsat;

   always_comb begin
      nc = (chan_cfg_ff == 3'd0) ? 1 : ((int'(chan_cfg_ff) > C) ? C : int'(chan_cfg_ff));
      nf = (filt_cfg_ff == 4'd0) ? 1 :
           ((int'(filt_cfg_ff) > MAX_FILTERS) ? MAX_FILTERS : int'(filt_cfg_ff));
      k  = (kern_cfg_ff == 3'd0) ? 1 : ((int'(kern_cfg_ff) > K) ? K : int'(kern_cfg_ff));
      w  = (width_cfg_ff == 9'd0) ? 1 :
           ((int'(width_cfg_ff) > MAX_WIDTH) ? MAX_WIDTH : int'(width_cfg_ff));
      h  = (height_cfg_ff == 9'd0) ? 1 : ((int'(height_cfg_ff) > 256) ? 256 : int'(height_cfg_ff));
   end

   assign adv        = !out_valid_ff || rsp_ready;
   assign last_issue = (int'(fcnt_ff) == nf - 1);
   assign req_ready  = !b_valid_ff && (!busy_ff || (last_issue && adv));
   assign accept     = req_valid && req_ready;
   assign pix_accept = accept && (req_data.req_type == cnv_pkg::REQ_PIXEL);

   always_comb begin
      col_i = (int'(col_ff) >= w) ? w - 1 : int'(col_ff);
      row_i = (int'(row_ff) >= h) ? h - 1 : int'(row_ff);
      r0_i  = row_i + 1 - k;
      c0_i  = col_i + 1 - k;
      emit  = (row_i + 1 >= k) && (col_i + 1 >= k);
      frame_end  = (row_i == h - 1) && (col_i == w - 1);
      packed_pix = {req_data.pix_c3, req_data.pix_c2, req_data.pix_c1, req_data.pix_c0};
   end

   for (genvar s = 0; s < K; s++) begin : g_line
      cnv_ram #(.WIDTH(64), .DEPTH(MAX_WIDTH)) u_line (
         .clock      (clock),
         .wr_en      (pix_accept && slot_ff == KIW'(s)),
         .wr_addr    (col_i[CW-1:0]),
         .wr_data    (packed_pix),
         .rd_addr    (col_i[CW-1:0]),
         .rd_data_ff (rd_data[s])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cfg_ff   <= 3'd1;
         filt_cfg_ff   <= 4'd1;
         kern_cfg_ff   <= 3'd3;
         width_cfg_ff  <= 9'd256;
         height_cfg_ff <= 9'd256;
         col_ff        <= '0;
         row_ff        <= '0;
         slot_ff       <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            cnv_pkg::CSR_CHANNELS: chan_cfg_ff   <= csr_wdata[2:0];
            cnv_pkg::CSR_FILTERS:  filt_cfg_ff   <= csr_wdata[3:0];
            cnv_pkg::CSR_KERNEL:   kern_cfg_ff   <= csr_wdata[2:0];
            cnv_pkg::CSR_WIDTH:    width_cfg_ff  <= csr_wdata;
            cnv_pkg::CSR_HEIGHT:   height_cfg_ff <= csr_wdata;
            default: ;
         endcase
         if (csr_index <= cnv_pkg::CSR_HEIGHT) begin
            col_ff  <= '0;
            row_ff  <= '0;
            slot_ff <= '0;
         end
      end else if (pix_accept) begin
         if (col_i + 1 >= w) begin
            col_ff <= '0;
            if (row_i + 1 >= h) begin
               row_ff  <= '0;
               slot_ff <= '0;
            end else begin
               row_ff  <= 8'(row_i + 1);
               slot_ff <= (int'(slot_ff) == K - 1) ? '0 : KIW'(int'(slot_ff) + 1);
            end
         end else begin
            col_ff <= CW'(col_i + 1);
            row_ff <= 8'(row_i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         b_emit_ff <= emit;
         b_fend_ff <= frame_end;
         b_slot_ff <= slot_ff;
         b_pix_ff  <= packed_pix;
         b_r0_ff   <= 8'(r0_i);
         b_c0_ff   <= 8'(c0_i);
      end
   end

   always_comb begin
      col_new[0] = b_pix_ff;
      for (int d = 1; d < K; d++) begin
         if (int'(b_slot_ff) >= d) begin
            col_new[d] = rd_data[KIW'(int'(b_slot_ff) - d)];
         end else begin
            col_new[d] = rd_data[KIW'(int'(b_slot_ff) + K - d)];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_valid_ff) begin
         for (int d = 0; d < K; d++) begin
            for (int e = K - 1; e > 0; e--) begin
               win_ff[d][e] <= win_ff[d][e-1];
            end
            win_ff[d][0] <= col_new[d];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         busy_ff    <= 1'b0;
         fcnt_ff    <= '0;
      end else begin
         b_valid_ff <= pix_accept;
         if (b_valid_ff && b_emit_ff) begin
            busy_ff <= 1'b1;
            fcnt_ff <= '0;
         end else if (busy_ff && adv) begin
            if (last_issue) begin
               busy_ff <= 1'b0;
            end
            fcnt_ff <= FW'(int'(fcnt_ff) + 1);
         end
      end
   end

   always_comb begin
      wf = 0;
      for (int f = 0; f < MAX_FILTERS; f++) begin
         if (int'(req_data.load_addr) >= f * CELLS) begin
            wf = f;
         end
      end
      widx = int'(req_data.load_addr) - wf * CELLS;
      if (req_data.load_value > 32'sd32767) begin
         wsat = 32'sd32767;
      end else if (req_data.load_value < -32'sd32768) begin
         wsat = -32'sd32768;
      end else begin
         wsat = req_data.load_value;
      end
      weight_wr.en    = accept && (req_data.req_type == cnv_pkg::REQ_WEIGHT) &&
                        (int'(req_data.load_addr) < MAX_FILTERS * CELLS);
      weight_wr.idx   = cnv_pkg::CELL_W'(widx);
      weight_wr.filt  = cnv_pkg::FILT_W'(wf);
      weight_wr.value = wsat[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int f = 0; f < MAX_FILTERS; f++) begin
            bias_ff[f] <= 32'sd0;
         end
      end else if (accept && req_data.req_type == cnv_pkg::REQ_BIAS &&
                   int'(req_data.load_addr) < MAX_FILTERS) begin
         bias_ff[req_data.load_addr[FW-1:0]] <= req_data.load_value;
      end
   end

   always_comb begin
      for (int c = 0; c < C; c++) begin
         for (int i = 0; i < K; i++) begin
            for (int j = 0; j < K; j++) begin
               use_tap[(c*K+i)*K+j] = (c < nc) && (i < k) && (j < k);
               if ((i < k) && (j < k)) begin
                  tap[(c*K+i)*K+j] = win_ff[KIW'(k-1-i)][KIW'(k-1-j)][16*c +: 16];
               end else begin
                  tap[(c*K+i)*K+j] = 16'sd0;
               end
            end
         end
      end
   end

   for (genvar n = 0; n < CELLS; n++) begin : g_cell
      cnv_cell #(.MAX_FILTERS(MAX_FILTERS), .CELL_ID(n)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .weight_wr (weight_wr),
         .adv       (adv),
         .use_tap   (use_tap[n]),
         .filt      (cnv_pkg::FILT_W'(fcnt_ff)),
         .tap       (tap[n]),
         .prod_ff   (prod[n])
      );
   end

   always_comb begin
      issue_meta.filt       = 3'(fcnt_ff);
      issue_meta.row        = b_r0_ff;
      issue_meta.col        = b_c0_ff;
      issue_meta.bias       = bias_ff[fcnt_ff];
      issue_meta.last_pixel = last_issue;
      issue_meta.last_frame = last_issue && b_fend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff   <= busy_ff;
         s1_valid_ff  <= p_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [VW-1:0] acc;
      if (adv) begin
         p_meta_ff  <= issue_meta;
         s1_meta_ff <= p_meta_ff;
         s2_meta_ff <= s1_meta_ff;
         for (int r = 0; r < C * K; r++) begin
            acc = '0;
            for (int j = 0; j < K; j++) begin
               acc = acc + VW'(prod[r*K+j]);
            end
            rsum_ff[r] <= acc;
         end
         for (int c = 0; c < C; c++) begin
            acc = '0;
            for (int i = 0; i < K; i++) begin
               acc = acc + rsum_ff[c*K+i];
            end
            csum_ff[c] <= acc;
         end
         acc = VW'(s2_meta_ff.bias);
         for (int c = 0; c < C; c++) begin
            acc = acc + csum_ff[c];
         end
         rsp_data_ff.out_filter    <= s2_meta_ff.filt;
         rsp_data_ff.out_row       <= s2_meta_ff.row;
         rsp_data_ff.out_col       <= s2_meta_ff.col;
         rsp_data_ff.out_value     <= acc;
         rsp_data_ff.last_of_pixel <= s2_meta_ff.last_pixel;
         rsp_data_ff.last_of_frame <= s2_meta_ff.last_frame;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_b_one_cycle: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff |=> !b_valid_ff)
      else $error("window shift stage held for more than one cycle");
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && b_valid_ff))
      else $error("new window shifted while filters still issuing");
   a_frame_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_of_frame) |-> rsp_data.last_of_pixel)
      else $error("frame end flagged on a result that is not last of pixel");
endmodule
